[rtl/hne_pkg.sv]
// shared constants and codes of the heightmap normal encoder
package hne_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int HGT_W     = 16;
    localparam int WID_W     = 13;
    localparam int SPAN_W    = 24;
    localparam int MUL_W     = 24;
    localparam int CH_W      = 10;

    // func codes of an input word
    localparam logic [1:0] F_SAMPLE = 2'd0;
    localparam logic [1:0] F_FRAME  = 2'd1;
    localparam logic [1:0] F_DRAIN  = 2'd2;
    localparam logic [1:0] F_NOP    = 2'd3;

    // configuration register indexes
    localparam logic CFG_FRAME_WIDTH = 1'b0;
    localparam logic CFG_HEIGHT_SPAN = 1'b1;

    // row phase codes
    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_FIRST  = 2'd1;
    localparam logic [1:0] PH_SECOND = 2'd2;
    localparam logic [1:0] PH_LATER  = 2'd3;

    localparam logic [WID_W-1:0]  WIDTH_RESET = 13'd2048;
    localparam logic [SPAN_W-1:0] SPAN_RESET  = 24'd524288;
    localparam logic [WID_W-1:0]  WIDTH_MIN   = 13'd2;
    localparam logic [WID_W-1:0]  WIDTH_MAX   = WID_W'(MAX_WIDTH);

    // 256 * 65535, the unscaled y component per unit of distance product
    localparam logic [40:0] Y_UNIT   = 41'd16776960;
    // 1023 squared
    localparam logic [MUL_W-1:0] SQ_1023 = 24'd1046529;
    localparam logic [CH_W-1:0]  CH_MID  = 10'd511;
    localparam logic [CH_W-1:0]  CH_TOP  = 10'd1023;

endpackage

[rtl/hne_ram.sv]
// generic simple dual-port ram with registered read
module hne_ram #(
    parameter int P_WIDTH = 16,
    parameter int P_DEPTH = 4096
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]         i_wdata,
    input  logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output logic [P_WIDTH-1:0]         o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/heightmap_normal_encoder_core.sv]
// top level of the heightmap normal encoder: line buffers and normal sequencer
//
// Height samples enter on the input channel (i_in_valid / o_in_stall) in raster
// order; func marks the first sample of a frame, a plain sample, or a drain
// word that flushes one pixel of the last row. Packed R10G10B10A2 normals leave
// on the output channel (o_out_valid / i_out_stall) one row behind the input.
// Two line-buffer rams of 4096 x 16 hold the older and newer row.
// A word of the first row, a no-op, or a drain while idle gives no result. A
// word that gives a result passes the ram reads (RD0, RD1, RD2), the products
// (PMX, PMZ, PMY), a shift loop that brings the components below 2^20, the
// squares (SQ, SQW per component), then three 10-step binary searches, each
// step (TST, ALO, AHI, ADEC) on the single shared 24 x 24 multiplier; a zero
// normal skips the searches and gives midscale channels.
// The output register holds one finished pixel; the next input word is taken
// while it waits. If the receiver stalls, the next result waits in the
// sequencer and the input stalls until the output register frees.
// Configuration writes are always ready and must be made while idle.
// Reset (synchronous, active low) clears column, row phase and control state and
// loads the register defaults; ram contents are undefined until written.
module heightmap_normal_encoder_core
    import hne_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_func,
    input  logic [HGT_W-1:0]  i_height_sample,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [31:0]       o_pixel_word,
    output logic              o_row_end,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_index,
    input  logic [SPAN_W-1:0] i_cfg_data
);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_RD0  = 5'd1;
    localparam logic [4:0] ST_RD1  = 5'd2;
    localparam logic [4:0] ST_RD2  = 5'd3;
    localparam logic [4:0] ST_PMX  = 5'd4;
    localparam logic [4:0] ST_PMZ  = 5'd5;
    localparam logic [4:0] ST_PMY  = 5'd6;
    localparam logic [4:0] ST_NORM = 5'd7;
    localparam logic [4:0] ST_SQ   = 5'd8;
    localparam logic [4:0] ST_SQW  = 5'd9;
    localparam logic [4:0] ST_CH   = 5'd10;
    localparam logic [4:0] ST_BHI  = 5'd11;
    localparam logic [4:0] ST_BACC = 5'd12;
    localparam logic [4:0] ST_TST  = 5'd13;
    localparam logic [4:0] ST_ALO  = 5'd14;
    localparam logic [4:0] ST_AHI  = 5'd15;
    localparam logic [4:0] ST_ADEC = 5'd16;
    localparam logic [4:0] ST_OUT  = 5'd17;

    logic [4:0]        r_state;
    logic [WID_W-1:0]  r_frame_width;
    logic [SPAN_W-1:0] r_height_span;
    logic [COL_W-1:0]  r_col;
    logic [1:0]        r_phase;
    logic              r_draining;

    logic [COL_W-1:0]  r_ecol;
    logic              r_elast;
    logic              r_efirst;
    logic              r_edrain;
    logic [1:0]        r_dz;
    logic [HGT_W-1:0]  r_hs;
    logic [HGT_W-1:0]  r_ctr;
    logic [HGT_W-1:0]  r_up;
    logic [HGT_W-1:0]  r_left;
    logic [HGT_W-1:0]  r_right;

    logic [47:0]       r_prod;
    logic [40:0]       r_m  [3];
    logic [39:0]       r_m2 [3];
    logic [41:0]       r_s2;
    logic [1:0]        r_k;
    logic              r_xneg;
    logic              r_zneg;
    logic [63:0]       r_a;
    logic [63:0]       r_b;
    logic [19:0]       r_tm2;
    logic [CH_W-1:0]   r_lo;
    logic [CH_W-1:0]   r_hi;
    logic [CH_W-1:0]   r_res [3];

    logic              r_out_valid;
    logic [31:0]       r_pixel_word;
    logic              r_row_end;

    // accept decode
    logic              w_in_acc;
    logic [WID_W-1:0]  w_width;
    logic              w_start;
    logic [COL_W-1:0]  n_col_e;
    logic [1:0]        n_phase_e;
    logic [WID_W-1:0]  w_col_inc;
    logic              w_last;
    logic [COL_W-1:0]  n_col;
    logic              w_fill;

    // datapath
    logic [HGT_W-1:0]  w_down;
    logic              w_lrneg;
    logic              w_udneg;
    logic [HGT_W-1:0]  w_lrmag;
    logic [HGT_W-1:0]  w_udmag;
    logic              w_sneg;
    logic [SPAN_W-1:0] w_smag;
    logic [1:0]        w_dx;
    logic [40:0]       w_my;
    logic              w_big;
    logic [CH_W:0]     w_sum;
    logic [CH_W-1:0]   w_mid;
    logic [CH_W:0]     w_t2;
    logic              w_tpos;
    logic [CH_W-1:0]   w_tm;
    logic [63:0]       w_a;
    logic              w_neg;
    logic              w_ok;
    logic              w_out_free;

    logic [MUL_W-1:0]  w_mul_a;
    logic [MUL_W-1:0]  w_mul_b;

    logic              w_old_we;
    logic              w_new_we;
    logic [COL_W-1:0]  w_waddr;
    logic [HGT_W-1:0]  w_old_wdata;
    logic [HGT_W-1:0]  w_new_wdata;
    logic [COL_W-1:0]  w_old_raddr;
    logic [COL_W-1:0]  w_new_raddr;
    logic [HGT_W-1:0]  w_old_rdata;
    logic [HGT_W-1:0]  w_new_rdata;

    function automatic logic [40:0] f_scale(input logic [47:0] p, input logic [1:0] d);
        logic [40:0] v;
        v = {1'b0, p[39:0]};
        unique case (d)
            2'd0:    f_scale = '0;
            2'd1:    f_scale = v;
            default: f_scale = {v[39:0], 1'b0};
        endcase
    endfunction

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && !o_in_stall;

    always_comb begin
        if (r_frame_width < WIDTH_MIN) begin
            w_width = WIDTH_MIN;
        end else if (r_frame_width > WIDTH_MAX) begin
            w_width = WIDTH_MAX;
        end else begin
            w_width = r_frame_width;
        end
    end

    assign w_start   = (i_func == F_FRAME) ||
                       ((i_func == F_SAMPLE) && ((r_phase == PH_IDLE) || r_draining));
    assign n_col_e   = w_start ? '0 : r_col;
    assign n_phase_e = w_start ? PH_FIRST : r_phase;
    assign w_col_inc = {1'b0, n_col_e} + WID_W'(1);
    assign w_last    = (w_col_inc >= w_width);
    assign n_col     = w_last ? '0 : w_col_inc[COL_W-1:0];
    assign w_fill    = w_in_acc && ((i_func == F_SAMPLE) || (i_func == F_FRAME)) &&
                       (n_phase_e == PH_FIRST);

    // line buffer ports
    always_comb begin
        w_old_we    = 1'b0;
        w_new_we    = 1'b0;
        w_waddr     = r_ecol;
        w_old_wdata = r_ctr;
        w_new_wdata = r_hs;
        if (r_state == ST_IDLE) begin
            w_old_we    = w_fill;
            w_new_we    = w_fill;
            w_waddr     = n_col_e;
            w_old_wdata = i_height_sample;
            w_new_wdata = i_height_sample;
        end else if (r_state == ST_RD2) begin
            w_old_we = 1'b1;
            w_new_we = !r_edrain;
        end
    end

    assign w_old_raddr = (r_state == ST_RD1) ? r_ecol - COL_W'(1) : r_ecol;
    assign w_new_raddr = (r_state == ST_RD1) ? r_ecol + COL_W'(1) : r_ecol;

    hne_ram #(.P_WIDTH(HGT_W), .P_DEPTH(MAX_WIDTH)) u_older (
        .i_clk   (i_clk),
        .i_we    (w_old_we),
        .i_waddr (w_waddr),
        .i_wdata (w_old_wdata),
        .i_raddr (w_old_raddr),
        .o_rdata (w_old_rdata)
    );

    hne_ram #(.P_WIDTH(HGT_W), .P_DEPTH(MAX_WIDTH)) u_newer (
        .i_clk   (i_clk),
        .i_we    (w_new_we),
        .i_waddr (w_waddr),
        .i_wdata (w_new_wdata),
        .i_raddr (w_new_raddr),
        .o_rdata (w_new_rdata)
    );

    // difference terms
    assign w_down  = r_edrain ? r_ctr : r_hs;
    assign w_lrneg = (r_right < r_left);
    assign w_udneg = (w_down < r_up);
    assign w_lrmag = w_lrneg ? r_left - r_right : r_right - r_left;
    assign w_udmag = w_udneg ? r_up - w_down : w_down - r_up;
    assign w_sneg  = r_height_span[SPAN_W-1];
    assign w_smag  = w_sneg ? SPAN_W'(0) - r_height_span : r_height_span;
    assign w_dx    = 2'(!r_efirst) + 2'(!r_elast);

    always_comb begin
        if ((r_dz == 2'd0) || (w_dx == 2'd0)) begin
            w_my = '0;
        end else begin
            w_my = Y_UNIT << (32'(r_dz == 2'd2) + 32'(w_dx == 2'd2));
        end
    end

    assign w_big = (r_m[0][40:20] != '0) || (r_m[1][40:20] != '0) ||
                   (r_m[2][40:20] != '0);

    // binary search probe
    assign w_sum  = {1'b0, r_lo} + {1'b0, r_hi} + (CH_W+1)'(1);
    assign w_mid  = w_sum[CH_W:1];
    assign w_t2   = {w_mid, 1'b0};
    assign w_tpos = w_mid[CH_W-1];
    assign w_tm   = w_tpos ? CH_W'(w_t2 - {1'b0, CH_TOP}) : CH_W'({1'b0, CH_TOP} - w_t2);
    assign w_a    = r_a + ({16'd0, r_prod} << 21);

    always_comb begin
        unique case (r_k)
            2'd0:    w_neg = r_xneg && (r_m[0][19:0] != '0);
            2'd2:    w_neg = r_zneg && (r_m[2][19:0] != '0);
            default: w_neg = 1'b0;
        endcase
    end

    assign w_ok = w_tpos ? (!w_neg && (w_a <= r_b)) : (!w_neg || (w_a >= r_b));

    // shared multiplier operands
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            ST_PMX: begin
                w_mul_a = MUL_W'(w_lrmag);
                w_mul_b = w_smag;
            end
            ST_PMZ: begin
                w_mul_a = MUL_W'(w_udmag);
                w_mul_b = w_smag;
            end
            ST_SQ: begin
                w_mul_a = MUL_W'(r_m[r_k][19:0]);
                w_mul_b = MUL_W'(r_m[r_k][19:0]);
            end
            ST_CH: begin
                w_mul_a = SQ_1023;
                w_mul_b = MUL_W'(r_m2[r_k][19:0]);
            end
            ST_BHI: begin
                w_mul_a = SQ_1023;
                w_mul_b = MUL_W'(r_m2[r_k][39:20]);
            end
            ST_TST: begin
                w_mul_a = MUL_W'(w_tm);
                w_mul_b = MUL_W'(w_tm);
            end
            ST_ALO: begin
                w_mul_a = MUL_W'(r_prod[19:0]);
                w_mul_b = MUL_W'(r_s2[20:0]);
            end
            ST_AHI: begin
                w_mul_a = MUL_W'(r_tm2);
                w_mul_b = MUL_W'(r_s2[41:21]);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
    end

    // configuration and control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_frame_width <= WIDTH_RESET;
            r_height_span <= SPAN_RESET;
            r_col         <= '0;
            r_phase       <= PH_IDLE;
            r_draining    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_FRAME_WIDTH: r_frame_width <= i_cfg_data[WID_W-1:0];
                    CFG_HEIGHT_SPAN: r_height_span <= i_cfg_data;
                endcase
            end
            if ((r_state == ST_OUT) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        unique case (i_func)
                            F_SAMPLE, F_FRAME: begin
                                r_col      <= n_col;
                                r_draining <= 1'b0;
                                if (n_phase_e == PH_FIRST) begin
                                    r_phase <= w_last ? PH_SECOND : PH_FIRST;
                                end else begin
                                    r_phase <= w_last ? PH_LATER : n_phase_e;
                                    r_state <= ST_RD0;
                                end
                            end
                            F_DRAIN: begin
                                if (r_phase != PH_IDLE) begin
                                    r_col      <= n_col;
                                    r_draining <= !w_last;
                                    r_phase    <= w_last ? PH_IDLE : r_phase;
                                    r_state    <= ST_RD0;
                                end
                            end
                            F_NOP: begin
                            end
                        endcase
                    end
                end
                ST_RD0:  r_state <= ST_RD1;
                ST_RD1:  r_state <= ST_RD2;
                ST_RD2:  r_state <= ST_PMX;
                ST_PMX:  r_state <= ST_PMZ;
                ST_PMZ:  r_state <= ST_PMY;
                ST_PMY:  r_state <= ST_NORM;
                ST_NORM: r_state <= w_big ? ST_NORM : ST_SQ;
                ST_SQ:   r_state <= ST_SQW;
                ST_SQW:  r_state <= (r_k == 2'd2) ? ST_CH : ST_SQ;
                ST_CH: begin
                    if (r_s2 != '0) begin
                        r_state <= ST_BHI;
                    end else if (r_k == 2'd2) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_BHI:  r_state <= ST_BACC;
                ST_BACC: r_state <= ST_TST;
                ST_TST: begin
                    if (r_lo < r_hi) begin
                        r_state <= ST_ALO;
                    end else begin
                        r_state <= (r_k == 2'd2) ? ST_OUT : ST_CH;
                    end
                end
                ST_ALO:  r_state <= ST_AHI;
                ST_AHI:  r_state <= ST_ADEC;
                ST_ADEC: r_state <= ST_TST;
                ST_OUT: begin
                    if (w_out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_ecol   <= n_col_e;
                r_elast  <= w_last;
                r_efirst <= (n_col_e == '0);
                r_edrain <= (i_func == F_DRAIN);
                r_hs     <= i_height_sample;
                if (i_func == F_DRAIN) begin
                    r_dz <= (r_phase == PH_LATER) ? 2'd1 : 2'd0;
                end else begin
                    r_dz <= (n_phase_e == PH_LATER) ? 2'd2 : 2'd1;
                end
            end
            ST_RD1: begin
                r_ctr <= w_new_rdata;
                r_up  <= w_old_rdata;
            end
            ST_RD2: begin
                r_left  <= r_efirst ? r_ctr : w_old_rdata;
                r_right <= r_elast ? r_ctr : w_new_rdata;
            end
            ST_PMX: begin
                r_xneg <= (w_lrneg == w_sneg);
                r_zneg <= (w_udneg == w_sneg);
            end
            ST_PMZ: r_m[0] <= f_scale(r_prod, r_dz);
            ST_PMY: begin
                r_m[2] <= f_scale(r_prod, w_dx);
                r_m[1] <= w_my;
            end
            ST_NORM: begin
                if (w_big) begin
                    r_m[0] <= r_m[0] >> 1;
                    r_m[1] <= r_m[1] >> 1;
                    r_m[2] <= r_m[2] >> 1;
                end else begin
                    r_k  <= 2'd0;
                    r_s2 <= '0;
                end
            end
            ST_SQW: begin
                r_m2[r_k] <= r_prod[39:0];
                r_s2      <= r_s2 + r_prod[41:0];
                r_k       <= (r_k == 2'd2) ? 2'd0 : r_k + 2'd1;
            end
            ST_CH: begin
                r_lo <= '0;
                r_hi <= CH_TOP;
                if (r_s2 == '0) begin
                    r_res[r_k] <= CH_MID;
                    r_k        <= r_k + 2'd1;
                end
            end
            ST_BHI:  r_b <= {16'd0, r_prod};
            ST_BACC: r_b <= r_b + ({16'd0, r_prod} << 20);
            ST_TST: begin
                if (!(r_lo < r_hi)) begin
                    r_res[r_k] <= r_lo;
                    r_k        <= r_k + 2'd1;
                end
            end
            ST_ALO:  r_tm2 <= r_prod[19:0];
            ST_AHI:  r_a   <= {16'd0, r_prod};
            ST_ADEC: begin
                if (w_ok) begin
                    r_lo <= w_mid;
                end else begin
                    r_hi <= w_mid - CH_W'(1);
                end
            end
            ST_OUT: begin
                if (w_out_free) begin
                    r_pixel_word <= {2'b11, r_res[2], r_res[1], r_res[0]};
                    r_row_end    <= r_elast;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_word = r_pixel_word;
    assign o_row_end    = r_row_end;

    // the search interval never inverts
    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TST) |-> (r_lo <= r_hi))
        else $error("search interval inverted");

    // squares only start once all components fit in 20 bits
    a_norm_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQ) |-> !w_big)
        else $error("component too wide for squaring");

    // a finished pixel always lands in the output register
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && w_out_free) |=> (o_out_valid && r_state == ST_IDLE))
        else $error("result not loaded");

    // a drain while idle leaves the block idle
    a_idle_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_func == F_DRAIN && r_phase == PH_IDLE)
        |=> (r_state == ST_IDLE && r_phase == PH_IDLE))
        else $error("drain while idle changed state");

endmodule
